>>> hw/rtl/mcss_pkg.sv
// types and constants shared by the min coin subset search block
package mcss_pkg;

	localparam int TargetWidth   = 20;
	localparam int CoinFieldW    = 16;
	localparam int NumFieldW     = 5;
	localparam int MaskFieldW    = 16;
	localparam int CountFieldW   = 5;
	localparam int SolItemsMax   = 16;

	localparam logic KindSolution = 1'b0;
	localparam logic KindDone     = 1'b1;

	typedef logic [TargetWidth-1:0] cfg_data_t;

	typedef struct packed {
		logic [CoinFieldW-1:0] coin_value;
		logic                  last_coin;
	} coin_item_t;

	typedef struct packed {
		logic                   result_kind;
		logic [NumFieldW-1:0]   solution_number;
		logic [MaskFieldW-1:0]  chosen_mask;
		logic [CountFieldW-1:0] chosen_count;
		logic                   final_result;
	} result_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TAKE,
		ST_RET,
		ST_RESTORE,
		ST_DONE
	} mcss_state_t;

endpackage

>>> hw/rtl/mcss_chan_if.sv
// valid/ready channel with a typed payload
interface mcss_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/mcss_ram.sv
// generic single-port-write, single-port-read ram with registered read
module mcss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                    wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                    rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> hw/rtl/min_coin_subset_search_top.sv
// top level of the min coin subset search: coin loading, dfs sequencer, result register
//
//  channel   dir  payload                                        transaction
//  coin_in   in   coin_value, last_coin                          one coin loaded
//  cfg_in    in   target_change (20 bits)                        register write
//  res_out   out  result_kind, solution_number, chosen_mask,     one result item
//                 chosen_count, final_result
//
// coins load one per cycle into the coin ram; the coin that carries last_coin, or the
// NUM_COINS-th, starts the depth-first search and coin_in stays low on ready until the
// done item is in the result register
// each visited node takes an evaluate and a return step, plus a take step for every take and a
// restore step for every restore, since the read of the coin ram is registered
// arst_n clears all control state; the coin ram has no reset and its read data is only used where written
// a full result register stalls the search only at a step that must report an item
module min_coin_subset_search_top #(
	parameter int NUM_COINS  = 16,
	parameter int COIN_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	mcss_chan_if.sink   coin_in,
	mcss_chan_if.sink   cfg_in,
	mcss_chan_if.source res_out
);
	import mcss_pkg::*;

	// address, depth and change widths
	localparam int AW = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
	localparam int DW = $clog2(NUM_COINS + 1);
	localparam int CW = ((COIN_WIDTH > TargetWidth) ? COIN_WIDTH : TargetWidth) + 2;

	mcss_state_t state_q, state_d;

	logic [TargetWidth-1:0] target_q;
	logic [DW-1:0]          coins_q;     // coins loaded in the current set
	logic [DW-1:0]          n_q;         // coin count of the set under search
	logic [DW-1:0]          d_q;         // coins decided on the current path
	logic [DW-1:0]          cnt_q;       // coins taken on the current path
	logic [DW-1:0]          best_q;
	logic [DW-1:0]          sol_q;       // improved solutions so far
	logic [NUM_COINS-1:0]   mask_q;      // take decisions on the current path
	logic signed [CW-1:0]   chg_q;       // change still to give

	logic                   out_valid_q;
	result_item_t           out_q;

	logic                   ram_we;
	logic [AW-1:0]          rd_addr;
	logic [COIN_WIDTH-1:0]  rd_data;
	logic [COIN_WIDTH-1:0]  coin_v;

	logic                   coin_acc;
	logic                   ends_set;
	logic                   can_load;
	logic                   at_zero;
	logic                   improve;
	logic                   room;
	logic                   emit_sol;
	logic                   emit_done;
	logic [AW-1:0]          d_idx;
	logic [AW-1:0]          p_idx;

	// coin store
	mcss_ram #(
		.WIDTH (COIN_WIDTH),
		.DEPTH (NUM_COINS)
	) u_coin_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (coins_q[AW-1:0]),
		.wr_data (coin_v),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign coin_v   = COIN_WIDTH'(coin_in.data.coin_value);
	assign coin_acc = coin_in.valid && coin_in.ready;
	assign ends_set = coin_in.data.last_coin || (coins_q == DW'(NUM_COINS - 1));
	assign can_load = !out_valid_q || res_out.ready;

	assign at_zero  = (chg_q == '0);
	assign improve  = (cnt_q < best_q);
	assign room     = (32'(sol_q) < SolItemsMax);
	assign d_idx    = d_q[AW-1:0];
	assign p_idx    = AW'(d_q - DW'(1));

	assign cfg_in.ready  = 1'b1;
	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (coin_acc && ends_set) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (at_zero) begin
					// solution node; wait only when an item has to go out
					if (!(improve && room) || can_load) begin
						state_d = ST_RET;
					end
				end else if (chg_q[CW-1] || (d_q >= n_q)) begin
					state_d = ST_RET;
				end else begin
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: state_d = ST_EVAL;
			ST_RET: begin
				if (d_q == '0) begin
					state_d = ST_DONE;
				end else if (mask_q[p_idx]) begin
					state_d = ST_RESTORE;
				end
			end
			ST_RESTORE: state_d = ST_EVAL;
			ST_DONE: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		coin_in.ready = 1'b0;
		ram_we        = 1'b0;
		rd_addr       = d_idx;
		emit_sol      = 1'b0;
		emit_done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				coin_in.ready = 1'b1;
				ram_we        = coin_in.valid;
			end
			ST_EVAL: begin
				rd_addr  = d_idx;
				emit_sol = at_zero && improve && room && can_load;
			end
			ST_RET: rd_addr = p_idx;
			ST_DONE: emit_done = can_load;
			default: ;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_in.valid && cfg_in.ready) begin
			target_q <= cfg_in.data;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coins_q <= '0;
			n_q     <= '0;
			d_q     <= '0;
			cnt_q   <= '0;
			best_q  <= '0;
			sol_q   <= '0;
			mask_q  <= '0;
			chg_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (coin_acc) begin
						if (ends_set) begin
							// search start: best is the coin count
							coins_q <= '0;
							n_q     <= coins_q + DW'(1);
							best_q  <= coins_q + DW'(1);
							sol_q   <= '0;
							d_q     <= '0;
							cnt_q   <= '0;
							mask_q  <= '0;
							chg_q   <= CW'(target_q);
						end else begin
							coins_q <= coins_q + DW'(1);
						end
					end
				end
				ST_EVAL: begin
					// improvement counts even when the item is not sent
					if (at_zero && improve && (!room || can_load)) begin
						best_q <= cnt_q;
						sol_q  <= sol_q + DW'(1);
					end
				end
				ST_TAKE: begin
					chg_q         <= chg_q - $signed(CW'(rd_data));
					mask_q[d_idx] <= 1'b1;
					cnt_q         <= cnt_q + DW'(1);
					d_q           <= d_q + DW'(1);
				end
				ST_RET: begin
					if ((d_q != '0) && !mask_q[p_idx]) begin
						d_q <= d_q - DW'(1);
					end
				end
				ST_RESTORE: begin
					// undo the take of the coin above, then try the skip branch
					chg_q         <= chg_q + $signed(CW'(rd_data));
					mask_q[p_idx] <= 1'b0;
					cnt_q         <= cnt_q - DW'(1);
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_sol || emit_done) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_sol) begin
			out_q.result_kind     <= KindSolution;
			out_q.solution_number <= NumFieldW'(sol_q + DW'(1));
			out_q.chosen_mask     <= MaskFieldW'(mask_q);
			out_q.chosen_count    <= CountFieldW'(cnt_q);
			out_q.final_result    <= 1'b0;
		end else if (emit_done) begin
			out_q.result_kind     <= KindDone;
			out_q.solution_number <= NumFieldW'(sol_q);
			out_q.chosen_mask     <= '0;
			out_q.chosen_count    <= CountFieldW'(best_q);
			out_q.final_result    <= 1'b1;
		end
	end
endmodule

>>> dv/min_coin_subset_search_checker.sv
// result checker for the min coin subset search: watches all three channels and predicts results
module min_coin_subset_search_checker #(
	parameter int NUM_COINS  = 16,
	parameter int COIN_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  coin_valid,
	input  logic                  coin_ready,
	input  mcss_pkg::coin_item_t   coin_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  mcss_pkg::cfg_data_t    cfg_data,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  mcss_pkg::result_item_t res_data,
	output int                    pending,
	output int                    fail_count
);
	import mcss_pkg::*;

	logic [COIN_WIDTH-1:0] coin_bank [NUM_COINS];
	int unsigned           coins_held;
	cfg_data_t             target_change;
	result_item_t          due_results [$];
	int                    fails;

	assign fail_count = fails;

	task automatic flag_mismatch(input string why, input result_item_t want,
			input result_item_t got);
		fails++;
		if (fails <= 10) begin
			$display("%0t mismatch (%s): exp kind=%0d num=%0d mask=%h cnt=%0d fin=%0d",
				$realtime, why, want.result_kind, want.solution_number, want.chosen_mask,
				want.chosen_count, want.final_result);
			$display("%0t                got kind=%0d num=%0d mask=%h cnt=%0d fin=%0d",
				$realtime, got.result_kind, got.solution_number, got.chosen_mask,
				got.chosen_count, got.final_result);
		end
	endtask

	// depth-first search over the loaded coins, take before skip, kept on an explicit stack
	function automatic void search_fewest_coins();
		logic [MaskFieldW-1:0] mask_stack [$];
		longint                change_stack [$];
		int unsigned           depth_stack [$];
		logic [MaskFieldW-1:0] mask;
		longint                change;
		int unsigned           depth;
		int unsigned           best;
		int unsigned           found;
		int unsigned           taken;
		result_item_t          item;

		best  = coins_held;
		found = 0;
		mask_stack.push_back('0);
		change_stack.push_back(longint'(target_change));
		depth_stack.push_back(0);
		while (depth_stack.size() != 0) begin
			mask   = mask_stack.pop_back();
			change = change_stack.pop_back();
			depth  = depth_stack.pop_back();
			if (change == 0) begin
				taken = $countones(mask);
				if (taken < best) begin
					best = taken;
					found++;
					if (found <= SolItemsMax) begin
						item.result_kind     = KindSolution;
						item.solution_number = NumFieldW'(found);
						item.chosen_mask     = mask;
						item.chosen_count    = CountFieldW'(taken);
						item.final_result    = 1'b0;
						due_results.push_back(item);
					end
				end
			end else if (change > 0 && depth < coins_held) begin
				// skip branch goes below the take branch so take is explored first
				mask_stack.push_back(mask);
				change_stack.push_back(change);
				depth_stack.push_back(depth + 1);
				mask_stack.push_back(mask | (MaskFieldW'(1) << depth));
				change_stack.push_back(change - longint'(coin_bank[depth]));
				depth_stack.push_back(depth + 1);
			end
		end
		item.result_kind     = KindDone;
		item.solution_number = NumFieldW'(found);
		item.chosen_mask     = '0;
		item.chosen_count    = CountFieldW'(best);
		item.final_result    = 1'b1;
		due_results.push_back(item);
	endfunction

	always @(posedge clk) begin
		result_item_t want;
		if (!arst_n) begin
			coins_held    = 0;
			target_change = '0;
			due_results.delete();
			fails         = 0;
			pending      <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("no result expected", '0, res_data);
				end else begin
					want = due_results.pop_front();
					if (res_data.result_kind !== want.result_kind ||
							res_data.solution_number !== want.solution_number ||
							res_data.chosen_mask !== want.chosen_mask ||
							res_data.chosen_count !== want.chosen_count ||
							res_data.final_result !== want.final_result) begin
						flag_mismatch("field", want, res_data);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				target_change = cfg_data;
			end
			if (coin_valid && coin_ready) begin
				if (coins_held < NUM_COINS) begin
					coin_bank[coins_held] = coin_data.coin_value[COIN_WIDTH-1:0];
					coins_held++;
				end
				if (coin_data.last_coin || coins_held >= NUM_COINS) begin
					search_fewest_coins();
					coins_held = 0;
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

>>> dv/min_coin_subset_search_top_tb.sv
// testbench top for the min coin subset search: clock, reset, coin and target stimulus, verdict
module min_coin_subset_search_top_tb;
	import mcss_pkg::*;

	localparam int          NumCoins   = 16;
	localparam int          CoinWidth  = 16;
	localparam int          RandomRun  = 86;
	localparam int          LongHold   = 400;
	localparam int unsigned CycleLimit = 1_000_000;

	// how the result sink paces its ready
	typedef enum logic [1:0] {
		PACE_OPEN,
		PACE_COIN_FLIP,
		PACE_ONE_IN_FOUR,
		PACE_MOSTLY_OPEN
	} pace_t;

	// value ranges for randomly built coin sets
	typedef enum logic [1:0] {
		VAL_SMALL,
		VAL_MEDIUM,
		VAL_FULL,
		VAL_HIGH
	} coin_range_t;

	logic clk = 1'b0;
	logic arst_n;

	mcss_chan_if #(.payload_t(coin_item_t))   coin_if ();
	mcss_chan_if #(.payload_t(cfg_data_t))    cfg_if ();
	mcss_chan_if #(.payload_t(result_item_t)) res_if ();

	int          chk_pending;
	int          chk_fails;
	int          hold_requests;
	int unsigned cycle_count;

	// coin sender state
	logic [CoinFieldW-1:0] coin_batch [$];
	bit                    coin_live;
	int unsigned           burst_left;
	int unsigned           coins_sent;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	min_coin_subset_search_top #(
		.NUM_COINS (NumCoins),
		.COIN_WIDTH(CoinWidth)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.coin_in(coin_if),
		.cfg_in (cfg_if),
		.res_out(res_if)
	);

	min_coin_subset_search_checker #(
		.NUM_COINS (NumCoins),
		.COIN_WIDTH(CoinWidth)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.coin_valid(coin_if.valid),
		.coin_ready(coin_if.ready),
		.coin_data (coin_if.data),
		.cfg_valid (cfg_if.valid),
		.cfg_ready (cfg_if.ready),
		.cfg_data  (cfg_if.data),
		.res_valid (res_if.valid),
		.res_ready (res_if.ready),
		.res_data  (res_if.data),
		.pending   (chk_pending),
		.fail_count(chk_fails)
	);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result sink: ready pattern switches at random between pacing styles,
	// and a long hold-off is served whenever the stimulus asks for one
	initial begin : sink_pacing
		pace_t       pace;
		int unsigned pace_left;
		int unsigned hold_left;
		int          holds_served;

		pace         = PACE_OPEN;
		pace_left    = 0;
		hold_left    = 0;
		holds_served = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LongHold;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				if (pace_left == 0) begin
					pace      = pace_t'($urandom_range(0, 3));
					pace_left = $urandom_range(16, 96);
				end
				pace_left--;
				case (pace)
					PACE_OPEN:        res_if.ready <= 1'b1;
					PACE_COIN_FLIP:   res_if.ready <= 1'($urandom_range(0, 1));
					PACE_ONE_IN_FOUR: res_if.ready <= (pace_left[1:0] == 2'd0);
					default:          res_if.ready <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// offer one coin and wait for its transaction; 'more' says another coin follows,
	// so valid may stay high inside a burst
	task automatic offer_coin(input logic [CoinFieldW-1:0] value, input logic last,
			input bit more);
		coin_item_t item;
		item.coin_value = value;
		item.last_coin  = last;
		coin_if.data <= item;
		if (!coin_live) begin
			coin_if.valid <= 1'b1;
			coin_live = 1'b1;
		end
		do @(posedge clk); while (!coin_if.ready);
		coins_sent++;
		if (more && burst_left != 0) begin
			burst_left--;
		end else begin
			coin_if.valid <= 1'b0;
			coin_live = 1'b0;
			if (more) begin
				// mostly short gaps, now and then a long one
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 30)) @(posedge clk);
				else
					repeat ($urandom_range(1, 3)) @(posedge clk);
				burst_left = $urandom_range(0, 20);
			end
		end
	endtask

	// send every coin of coin_batch; flag_end puts last_coin on the final coin
	task automatic play_set(input bit flag_end, input bit more);
		int unsigned k;
		for (k = 0; k < coin_batch.size(); k++) begin
			offer_coin(coin_batch[k], (k == coin_batch.size() - 1) ? flag_end : 1'b0,
				more || (k != coin_batch.size() - 1));
		end
	endtask

	// target may only change while the block is idle: drain, let it settle, then write
	task automatic write_target(input cfg_data_t value);
		do @(posedge clk); while (chk_pending != 0);
		repeat (4) @(posedge clk);
		cfg_if.data  <= value;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [CoinFieldW-1:0] random_coin(input coin_range_t span);
		case (span)
			VAL_SMALL:  return CoinFieldW'($urandom_range(0, 7));
			VAL_MEDIUM: return CoinFieldW'($urandom_range(0, 255));
			VAL_FULL:   return CoinFieldW'($urandom());
			default:    return CoinFieldW'($urandom_range(16'h8000, 16'hFFFF));
		endcase
	endfunction

	function automatic void build_batch(input int unsigned count, input coin_range_t span);
		coin_batch.delete();
		repeat (count) coin_batch.push_back(random_coin(span));
	endfunction

	// a target reachable from the current batch, so the search finds something
	function automatic cfg_data_t reachable_target();
		cfg_data_t sum;
		sum = '0;
		foreach (coin_batch[i]) begin
			if ($urandom_range(0, 1) != 0)
				sum += cfg_data_t'(coin_batch[i]);
		end
		return sum;
	endfunction

	initial begin : stimulus
		int unsigned random_from;
		int unsigned set_count;
		int unsigned big_sets;
		int unsigned size_pick;
		int unsigned target_pick;
		int unsigned a;
		int unsigned b;
		coin_range_t span;
		bit          end_flag;

		arst_n        <= 1'b0;
		coin_if.valid <= 1'b0;
		coin_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		hold_requests <= 0;
		cycle_count   <= 0;
		coin_live   = 1'b0;
		burst_left  = 0;
		coins_sent  = 0;
		set_count   = 0;
		big_sets    = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero target: the empty subset counts as a solution straight away
		write_target('0);
		coin_batch = '{16'd5};
		play_set(1'b1, 1'b0);

		// largest target with the widest and the zero coin: nothing fits
		write_target(20'hFFFFF);
		coin_batch = '{16'hFFFF, 16'h0000};
		play_set(1'b1, 1'b0);

		// improvements one after another: three coins, then two, then one
		write_target(20'd6);
		coin_batch = '{16'd1, 16'd2, 16'd3, 16'd3, 16'd6};
		play_set(1'b1, 1'b0);

		// a full store ends the set on its own, no last_coin flag
		write_target(20'd2);
		coin_batch.delete();
		repeat (NumCoins) coin_batch.push_back(16'd1);
		play_set(1'b0, 1'b0);

		random_from = coins_sent;
		while (coins_sent - random_from < RandomRun) begin
			set_count++;
			if (set_count == 3) begin
				// back pressure: results are held off for a long stretch while two sets
				// are offered back to back, so the search stalls and the input backs up
				build_batch(6, VAL_SMALL);
				foreach (coin_batch[i]) coin_batch[i] = CoinFieldW'($urandom_range(1, 3));
				write_target(reachable_target());
				hold_requests <= hold_requests + 1;
				play_set(1'b1, 1'b1);
				build_batch($urandom_range(2, 6), VAL_SMALL);
				play_set(1'b1, 1'b0);
				continue;
			end

			size_pick = $urandom_range(0, 19);
			if (size_pick == 19 && big_sets < 2) begin
				// a full store of big coins; target is two of them, so the search
				// is cut off after a few takes
				big_sets++;
				build_batch(NumCoins, VAL_HIGH);
				a = $urandom_range(0, NumCoins - 1);
				b = (a + $urandom_range(1, NumCoins - 1)) % NumCoins;
				write_target(cfg_data_t'(coin_batch[a]) + cfg_data_t'(coin_batch[b]));
				end_flag = 1'($urandom_range(0, 1));
				play_set(end_flag, 1'b0);
				continue;
			end

			a = $urandom_range(0, 9);
			span = (a < 6) ? VAL_SMALL : (a < 8) ? VAL_MEDIUM : VAL_FULL;
			build_batch((size_pick < 14) ? $urandom_range(1, 6) : $urandom_range(7, 10), span);

			target_pick = $urandom_range(0, 9);
			if (target_pick < 7) begin
				write_target(reachable_target());
			end else if (target_pick == 7) begin
				write_target(cfg_data_t'($urandom()));
			end else if (target_pick == 8) begin
				write_target(($urandom_range(0, 1) != 0) ? 20'hFFFFF : 20'h00000);
			end else begin
				// keep the old target, start while the block may still be searching
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			play_set(1'b1, 1'b0);
		end

		// every result in, then a quiet tail
		do @(posedge clk); while (chk_pending != 0);
		repeat (20) @(posedge clk);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
